@@ hdl/djb2krt_pkg.sv @@
// Package with the types and constants of the keyed record table.
package djb2krt_pkg;

    // Controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FIX,
        ST_MUL,
        ST_SCALE,
        ST_REDUCE,
        ST_READ,
        ST_EXEC
    } state_t;

    // Operation codes, carried in the input tuser
    localparam logic [1:0] OP_ADD  = 2'd0;
    localparam logic [1:0] OP_EDIT = 2'd1;
    localparam logic [1:0] OP_FIND = 2'd2;

    // Result status codes, carried in the output tuser
    localparam logic [2:0] STAT_STORED    = 3'd0;
    localparam logic [2:0] STAT_COLLISION = 3'd1;
    localparam logic [2:0] STAT_UPDATED   = 3'd2;
    localparam logic [2:0] STAT_FOUND     = 3'd3;
    localparam logic [2:0] STAT_NOT_FOUND = 3'd4;

    // Hash seed and the score shown when nothing is found (minus 100 as a signed value)
    localparam logic [31:0] HASH_SEED = 32'd5381;
    localparam logic [15:0] NO_SCORE  = 16'hFF9C;

    // Field widths
    localparam int unsigned ID_W    = 32;
    localparam int unsigned GPA_W   = 16;
    localparam int unsigned SLOT_W  = 12;
    localparam int unsigned HASH_W  = 32;

endpackage

@@ hdl/djb2_keyed_record_table_unit.sv @@
// Direct-mapped record table keyed by a byte-string hash, with its memories and controller.

// Key bytes arrive one per request and are folded into a 32-bit running hash
// (hash*33 plus the byte as a signed value, zero bytes skipped) at one byte per
// cycle. The request marked tlast runs the table operation given in tuser: the
// hash is made non-negative, reduced modulo TABLE_SIZE by a multiplication with
// the reciprocal of TABLE_SIZE followed by one correcting subtraction, and the
// slot is then read and written back in the ID and score memories. A last byte
// therefore occupies the block through the accept, sign fix, multiply, scale,
// reduce, memory read and decide-and-write steps before the next byte is taken;
// the decide step repeats while an earlier result still waits to be taken. The
// result waits in an output register, so the next key may stream in while it
// is pending. After reset the block sweeps the score memory to zero, one slot
// per cycle, and accepts no request until the sweep has passed the last slot. A slot counts as
// occupied while its score is positive.
module djb2_keyed_record_table_unit #(
    parameter int unsigned TABLE_SIZE = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,  // name_byte[7:0], student_id[39:8], gpa_value[55:40]
    input  logic [1:0]  s_axis_tuser,  // opcode[1:0]
    input  logic        s_axis_tlast,  // last_of_name
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,  // slot_index[11:0], found_id[43:12], found_gpa[59:44]
    output logic [2:0]  m_axis_tuser   // status[2:0]
);
    import djb2krt_pkg::*;

    localparam int unsigned SW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam logic [SW-1:0] LAST_SLOT = SW'(TABLE_SIZE - 1);

    // Reciprocal scaled so that the estimated quotient is exact or one too small
    localparam int unsigned SHIFT = 31 + SW;
    localparam logic [31:0] RECIP = 32'((64'd1 << SHIFT) / 64'(TABLE_SIZE));
    localparam logic [31:0] MOD32 = 32'(TABLE_SIZE);

    // Memories
    logic [ID_W-1:0]  id_mem  [TABLE_SIZE];
    logic [GPA_W-1:0] gpa_mem [TABLE_SIZE];

    // Control registers
    state_t            state_reg, state_next;
    logic [HASH_W-1:0] hash_reg, hash_next;
    logic [SW-1:0]     clr_cnt_reg, clr_cnt_next;
    logic              out_valid_reg, out_valid_next;

    // Payload registers
    logic [HASH_W-1:0] work_reg, work_next;
    logic [31:0]       quot_reg, quot_next;
    logic [SW-1:0]     rem_reg, rem_next;
    logic [1:0]        op_reg, op_next;
    logic [ID_W-1:0]   id_reg, id_next;
    logic [GPA_W-1:0]  gpa_reg, gpa_next;
    logic [2:0]        stat_reg, stat_next;
    logic [SW-1:0]     slot_out_reg, slot_out_next;
    logic [ID_W-1:0]   fid_reg, fid_next;
    logic [GPA_W-1:0]  fgpa_reg, fgpa_next;

    // Memory port signals
    logic              id_we, gpa_we;
    logic [SW-1:0]     mem_waddr;
    logic [GPA_W-1:0]  gpa_wdata;
    logic [ID_W-1:0]   id_rdata;
    logic [GPA_W-1:0]  gpa_rdata;

    // Request fields
    logic [7:0]        in_byte;
    logic [HASH_W-1:0] folded;
    logic [63:0]       prod_wide;
    logic [31:0]       diff;
    logic              occupied;
    logic              out_free;

    assign in_byte  = s_axis_tdata[7:0];
    assign out_free = !out_valid_reg || m_axis_tready;
    assign occupied = (gpa_rdata != '0) && !gpa_rdata[GPA_W-1];

    // One djb2 step: hash*33 plus the sign-extended byte
    assign folded = (hash_reg << 5) + hash_reg + {{(HASH_W-8){in_byte[7]}}, in_byte};

    // Hash times the reciprocal, and what is left after the quotient times the modulus
    assign prod_wide = 64'(work_reg) * 64'(RECIP);
    assign diff      = work_reg - quot_reg;

    // Next state, datapath and memory controls
    always_comb
    begin
        state_next     = state_reg;
        hash_next      = hash_reg;
        clr_cnt_next   = clr_cnt_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        work_next      = work_reg;
        quot_next      = quot_reg;
        rem_next       = rem_reg;
        op_next        = op_reg;
        id_next        = id_reg;
        gpa_next       = gpa_reg;
        stat_next      = stat_reg;
        slot_out_next  = slot_out_reg;
        fid_next       = fid_reg;
        fgpa_next      = fgpa_reg;
        s_axis_tready  = 1'b0;
        id_we          = 1'b0;
        gpa_we         = 1'b0;
        mem_waddr      = rem_reg;
        gpa_wdata      = gpa_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                gpa_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                gpa_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == LAST_SLOT)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    if (s_axis_tlast)
                    begin
                        work_next  = (in_byte != 8'd0) ? folded : hash_reg;
                        hash_next  = HASH_SEED;
                        op_next    = s_axis_tuser;
                        id_next    = s_axis_tdata[39:8];
                        gpa_next   = s_axis_tdata[55:40];
                        state_next = ST_FIX;
                    end
                    else if (in_byte != 8'd0)
                    begin
                        hash_next = folded;
                    end
                end
            end
            ST_FIX:
            begin
                // A negative hash becomes its negation plus one
                if (work_reg[HASH_W-1])
                begin
                    work_next = (~work_reg) + 32'd2;
                end
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                // Estimated quotient
                quot_next  = 32'(prod_wide >> SHIFT);
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                // The quotient register now holds the quotient times the modulus
                quot_next  = quot_reg * MOD32;
                state_next = ST_REDUCE;
            end
            ST_REDUCE:
            begin
                // The difference is below twice the modulus, so one subtraction finishes it
                rem_next   = (diff >= MOD32) ? SW'(diff - MOD32) : SW'(diff);
                state_next = ST_READ;
            end
            ST_READ:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    state_next    = ST_IDLE;
                    slot_out_next = rem_reg;
                    fid_next      = '0;
                    fgpa_next     = NO_SCORE;
                    case (op_reg)
                        OP_ADD:
                        begin
                            out_valid_next = 1'b1;
                            if (occupied)
                            begin
                                stat_next = STAT_COLLISION;
                            end
                            else
                            begin
                                id_we     = 1'b1;
                                gpa_we    = 1'b1;
                                stat_next = STAT_STORED;
                            end
                        end
                        OP_EDIT:
                        begin
                            out_valid_next = 1'b1;
                            id_we          = 1'b1;
                            gpa_we         = 1'b1;
                            stat_next      = STAT_UPDATED;
                        end
                        OP_FIND:
                        begin
                            out_valid_next = 1'b1;
                            if (occupied)
                            begin
                                stat_next = STAT_FOUND;
                                fid_next  = id_rdata;
                                fgpa_next = gpa_rdata;
                            end
                            else
                            begin
                                stat_next = STAT_NOT_FOUND;
                            end
                        end
                        default:
                        begin
                            // Unused opcode: no result and no write
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            hash_reg      <= HASH_SEED;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hash_reg      <= hash_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        work_reg     <= work_next;
        quot_reg     <= quot_next;
        rem_reg      <= rem_next;
        op_reg       <= op_next;
        id_reg       <= id_next;
        gpa_reg      <= gpa_next;
        stat_reg     <= stat_next;
        slot_out_reg <= slot_out_next;
        fid_reg      <= fid_next;
        fgpa_reg     <= fgpa_next;
    end

    // ID memory: one write port, registered read of the current slot
    always_ff @(posedge clk)
    begin
        if (id_we)
        begin
            id_mem[mem_waddr] <= id_reg;
        end
        id_rdata <= id_mem[rem_reg];
    end

    // Score memory: cleared by the sweep after reset, then read and written per operation
    always_ff @(posedge clk)
    begin
        if (gpa_we)
        begin
            gpa_mem[mem_waddr] <= gpa_wdata;
        end
        gpa_rdata <= gpa_mem[rem_reg];
    end

    // Output channel
    logic [31:0] slot_wide;
    assign slot_wide     = {{(32-SW){1'b0}}, slot_out_reg};
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = stat_reg;
    assign m_axis_tdata  = {4'd0, fgpa_reg, fid_reg, slot_wide[SLOT_W-1:0]};

endmodule
